// ----- rtl/core/ucl_pkg.sv -----
package ucl_pkg;

  // Sizing of the chaser
  localparam int LED_NUMBER   = 5;
  localparam int COUNTER_BITS = 16;
  localparam int LED_IDX_W    = (LED_NUMBER > 1) ? $clog2(LED_NUMBER) : 1;

  // Field widths of the ports
  localparam int BYTE_W      = 8;
  localparam int LED_DRIVE_W = 5;
  localparam int LED_POS_W   = 3;
  localparam int PERIOD_W    = 10;

  // Matcher sizing
  localparam int CMD_COUNT   = 5;
  localparam int CMD_MAXLEN  = 10;
  localparam int CMD_TEXT_W  = CMD_MAXLEN * BYTE_W;
  localparam int POS_W       = 4;
  localparam logic [POS_W-1:0] POS_MAX = 4'd15;

  // Line terminators
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  typedef logic [LED_NUMBER-1:0]   pins_t;
  typedef logic [LED_IDX_W-1:0]    led_idx_t;
  typedef logic [COUNTER_BITS-1:0] count_t;
  typedef logic [PERIOD_W-1:0]     period_t;
  typedef logic [LED_DRIVE_W-1:0]  drive_t;
  typedef logic [LED_POS_W-1:0]    led_pos_t;
  typedef logic [POS_W-1:0]        match_pos_t;
  typedef logic [CMD_COUNT-1:0]    cand_t;

  localparam pins_t   LEDS_OFF       = '1;
  localparam period_t PERIOD_START   = 10'd200;
  localparam period_t PERIOD_SPD100  = 10'd100;
  localparam period_t PERIOD_SPD500  = 10'd500;
  localparam period_t PERIOD_SPD1000 = 10'd1000;

  // Command table, left aligned, zero padded
  localparam logic [CMD_TEXT_W-1:0] TXT_START    = {"start", 40'h0};
  localparam logic [CMD_TEXT_W-1:0] TXT_STOP     = {"stop", 48'h0};
  localparam logic [CMD_TEXT_W-1:0] TXT_SPD100   = {"speed:100", 8'h0};
  localparam logic [CMD_TEXT_W-1:0] TXT_SPD500   = {"speed:500", 8'h0};
  localparam logic [CMD_TEXT_W-1:0] TXT_SPD1000  = "speed:1000";

  typedef enum logic [2:0] {
    HIT_START    = 3'd0,
    HIT_STOP     = 3'd1,
    HIT_SPD100   = 3'd2,
    HIT_SPD500   = 3'd3,
    HIT_SPD1000  = 3'd4,
    HIT_NONE     = 3'd5
  } hit_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_BYTE = 2'd1,
    OP_LINE = 2'd2
  } op_kind_e;

  typedef enum logic [2:0] {
    RES_NONE     = 3'd0,
    RES_START    = 3'd1,
    RES_STOP     = 3'd2,
    RES_SPD100   = 3'd3,
    RES_SPD500   = 3'd4,
    RES_SPD1000  = 3'd5,
    RES_IGNORED  = 3'd6
  } res_e;

  // Classified item passed from front to back
  typedef struct packed {
    op_kind_e kind;
    hit_e     hit;
  } op_t;

  // One result as it leaves the block
  typedef struct packed {
    drive_t   led_drive;
    period_t  period_ms;
    led_pos_t led_position;
    res_e     command_result;
  } result_t;

  function automatic match_pos_t cmd_len(hit_e c);
    match_pos_t len;
    unique case (c)
      HIT_START:   len = 4'd5;
      HIT_STOP:    len = 4'd4;
      HIT_SPD100:  len = 4'd9;
      HIT_SPD500:  len = 4'd9;
      HIT_SPD1000: len = 4'd10;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [BYTE_W-1:0] cmd_char(hit_e c, match_pos_t pos);
    logic [CMD_TEXT_W-1:0] txt;
    logic [BYTE_W-1:0]     ch;
    unique case (c)
      HIT_START:   txt = TXT_START;
      HIT_STOP:    txt = TXT_STOP;
      HIT_SPD100:  txt = TXT_SPD100;
      HIT_SPD500:  txt = TXT_SPD500;
      HIT_SPD1000: txt = TXT_SPD1000;
      default:     txt = '0;
    endcase
    ch = '0;
    for (int i = 0; i < CMD_MAXLEN; i++) begin
      if (pos == match_pos_t'(i)) begin
        ch = txt[CMD_TEXT_W-1-BYTE_W*i -: BYTE_W];
      end
    end
    return ch;
  endfunction

endpackage

// ----- rtl/core/uart_command_led_chaser.sv -----
// LED chaser driven by text commands and millisecond ticks.
// Input channel: push an item while full is low. command_i = 0 carries one
// received line byte in rx_byte_i, with line_end_i set on the line's last
// byte; command_i = 1 is a one millisecond tick.
// Result channel: while empty is low the oldest result stands on
// led_drive_o (active low), period_ms_o, led_position_o and
// command_result_o; pop takes it. Every item gives exactly one result.
// An item pushed is classified into a two-entry op queue, executed from
// there, and its result is written into the result queue, from which it can
// be popped. Throughput: one item per cycle while the result queue has room,
// set by the execute step (counter add and period compare).
// When the receiver stops popping, the two-entry result queue fills, the
// execute step holds, the op queue fills and full rises; nothing is lost.
// Reset: period 0, counter 0, ticking enabled, all LEDs off, LED index 0,
// matcher cleared, both queues empty.
module uart_command_led_chaser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                command_i,
  input  logic [ucl_pkg::BYTE_W-1:0]          rx_byte_i,
  input  logic                                line_end_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [ucl_pkg::LED_DRIVE_W-1:0]     led_drive_o,
  output logic [ucl_pkg::PERIOD_W-1:0]        period_ms_o,
  output logic [ucl_pkg::LED_POS_W-1:0]       led_position_o,
  output logic [2:0]                          command_result_o
);

  logic             accept;
  ucl_pkg::op_t     front_op, queue_op;
  logic             queue_valid, queue_pop;
  ucl_pkg::result_t result;

  assign accept = push && !full;

  // Classify incoming items
  ucl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (command_i),
    .rx_byte_i  (rx_byte_i),
    .line_end_i (line_end_i),
    .op_o       (front_op)
  );

  // Decouple front from back
  ucl_op_queue u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .op_i    (front_op),
    .full_o  (full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .op_o    (queue_op)
  );

  // Execute commands and ticks
  ucl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (queue_valid),
    .op_i       (queue_op),
    .op_pop_o   (queue_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result)
  );

  assign led_drive_o      = result.led_drive;
  assign period_ms_o      = result.period_ms;
  assign led_position_o   = result.led_position;
  assign command_result_o = result.command_result;

endmodule

// ----- rtl/core/ucl_front.sv -----
module ucl_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic                              command_i,
  input  logic [ucl_pkg::BYTE_W-1:0]        rx_byte_i,
  input  logic                              line_end_i,
  output ucl_pkg::op_t                      op_o
);

  ucl_pkg::match_pos_t pos_q, pos_d;
  ucl_pkg::cand_t      alive_q, alive_d;
  logic                term_q, term_d;
  logic                is_term;
  ucl_pkg::hit_e       hit;

  assign is_term = (rx_byte_i == ucl_pkg::CHAR_CR) || (rx_byte_i == ucl_pkg::CHAR_LF) ||
                   (rx_byte_i == ucl_pkg::CHAR_NUL);

  // Match the byte against every command and pick the hit at line end
  always_comb begin
    pos_d   = pos_q;
    alive_d = alive_q;
    term_d  = term_q;
    hit     = ucl_pkg::HIT_NONE;
    if (!term_q) begin
      if (is_term) begin
        term_d = 1'b1;
      end else begin
        for (int c = 0; c < ucl_pkg::CMD_COUNT; c++) begin
          if (!((pos_q < ucl_pkg::cmd_len(ucl_pkg::hit_e'(c))) &&
                (ucl_pkg::cmd_char(ucl_pkg::hit_e'(c), pos_q) == rx_byte_i))) begin
            alive_d[c] = 1'b0;
          end
        end
        if (pos_q < ucl_pkg::POS_MAX) begin
          pos_d = pos_q + ucl_pkg::match_pos_t'(1);
        end
      end
    end
    for (int c = 0; c < ucl_pkg::CMD_COUNT; c++) begin
      if (alive_d[c] && (ucl_pkg::cmd_len(ucl_pkg::hit_e'(c)) == pos_d)) begin
        hit = ucl_pkg::hit_e'(c);
      end
    end
  end

  // Classify the item for the back part
  always_comb begin
    op_o.hit = hit;
    if (command_i) begin
      op_o.kind = ucl_pkg::OP_TICK;
    end else if (line_end_i) begin
      op_o.kind = ucl_pkg::OP_LINE;
    end else begin
      op_o.kind = ucl_pkg::OP_BYTE;
    end
  end

  // Advance the matcher on bytes, clear it at line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      alive_q <= '1;
      term_q  <= 1'b0;
    end else if (accept_i && !command_i) begin
      if (line_end_i) begin
        pos_q   <= '0;
        alive_q <= '1;
        term_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        alive_q <= alive_d;
        term_q  <= term_d;
      end
    end
  end

endmodule

// ----- rtl/core/ucl_op_queue.sv -----
module ucl_op_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ucl_pkg::op_t  op_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ucl_pkg::op_t  op_o
);

  ucl_pkg::op_t mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;
  logic         do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store the classified item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/ucl_back.sv -----
module ucl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  ucl_pkg::op_t      op_i,
  output logic              op_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output ucl_pkg::result_t  result_o
);

  ucl_pkg::period_t  per_q, per_d;
  ucl_pkg::count_t   cnt_q, cnt_d;
  logic              en_q, en_d;
  ucl_pkg::pins_t    pins_q, pins_d;
  ucl_pkg::led_idx_t lit_q, lit_d;
  ucl_pkg::res_e     res;
  ucl_pkg::result_t  res_item;

  ucl_pkg::result_t  out_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              out_full, fire, do_pop;

  assign out_full = (count_q == 2'd2);
  assign empty_o  = (count_q == 2'd0);
  assign fire     = op_valid_i && !out_full;
  assign op_pop_o = fire;
  assign do_pop   = pop_i && !empty_o;
  assign result_o = out_q[rd_ptr_q];

  // Carry out the command or tick, then run the step check
  always_comb begin
    per_d  = per_q;
    cnt_d  = cnt_q;
    en_d   = en_q;
    pins_d = pins_q;
    lit_d  = lit_q;
    res    = ucl_pkg::RES_NONE;
    if (op_i.kind == ucl_pkg::OP_TICK) begin
      if (en_q) begin
        cnt_d = cnt_q + ucl_pkg::count_t'(1);
      end
    end else if (op_i.kind == ucl_pkg::OP_LINE) begin
      res = ucl_pkg::RES_IGNORED;
      unique case (op_i.hit)
        ucl_pkg::HIT_START: begin
          per_d = ucl_pkg::PERIOD_START;
          en_d  = 1'b1;
          res   = ucl_pkg::RES_START;
        end
        ucl_pkg::HIT_STOP: begin
          per_d  = '0;
          en_d   = 1'b0;
          pins_d = ucl_pkg::LEDS_OFF;
          res    = ucl_pkg::RES_STOP;
        end
        ucl_pkg::HIT_SPD100: begin
          if (per_q != '0) begin
            per_d = ucl_pkg::PERIOD_SPD100;
            res   = ucl_pkg::RES_SPD100;
          end
        end
        ucl_pkg::HIT_SPD500: begin
          if (per_q != '0) begin
            per_d = ucl_pkg::PERIOD_SPD500;
            res   = ucl_pkg::RES_SPD500;
          end
        end
        ucl_pkg::HIT_SPD1000: begin
          if (per_q != '0) begin
            per_d = ucl_pkg::PERIOD_SPD1000;
            res   = ucl_pkg::RES_SPD1000;
          end
        end
        default: begin
          res = ucl_pkg::RES_IGNORED;
        end
      endcase
    end
    if ((per_d != '0) && (cnt_d >= ucl_pkg::count_t'(per_d))) begin
      cnt_d  = '0;
      pins_d = ucl_pkg::LEDS_OFF & ~(ucl_pkg::pins_t'(1) << lit_q);
      if (lit_q == ucl_pkg::led_idx_t'(ucl_pkg::LED_NUMBER - 1)) begin
        lit_d = '0;
      end else begin
        lit_d = lit_q + ucl_pkg::led_idx_t'(1);
      end
    end
  end

  // Pack the result fields
  always_comb begin
    res_item.led_drive      = ucl_pkg::drive_t'(pins_d);
    res_item.period_ms      = per_d;
    res_item.led_position   = ucl_pkg::led_pos_t'(lit_d);
    res_item.command_result = res;
  end

  // Hold chaser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q  <= '0;
      cnt_q  <= '0;
      en_q   <= 1'b1;
      pins_q <= ucl_pkg::LEDS_OFF;
      lit_q  <= '0;
    end else if (fire) begin
      per_q  <= per_d;
      cnt_q  <= cnt_d;
      en_q   <= en_d;
      pins_q <= pins_d;
      lit_q  <= lit_d;
    end
  end

  // Store results for the receiver
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q[wr_ptr_q] <= res_item;
    end
  end

  // Track result queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (fire) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (fire && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !fire) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("result queue overfilled");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res == ucl_pkg::RES_STOP) |=>
      (per_q == '0) && (pins_q == ucl_pkg::LEDS_OFF) && !en_q)
    else $error("stop left the chaser running");

  a_period_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (per_q == '0) || (per_q == ucl_pkg::PERIOD_START) || (per_q == ucl_pkg::PERIOD_SPD100) ||
    (per_q == ucl_pkg::PERIOD_SPD500) || (per_q == ucl_pkg::PERIOD_SPD1000))
    else $error("illegal step period");

  a_lit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q <= ucl_pkg::led_idx_t'(ucl_pkg::LED_NUMBER - 1))
    else $error("LED index out of range");

  a_speed_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (res == ucl_pkg::RES_SPD100 || res == ucl_pkg::RES_SPD500 ||
              res == ucl_pkg::RES_SPD1000)) |-> (per_q != '0))
    else $error("speed change applied while stopped");
`endif

endmodule

// ----- verif/uart_command_led_chaser_test.sv -----
module uart_command_led_chaser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ucl_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 90;
  localparam int IDLE_TICKS   = 210;

  typedef logic [BYTE_W-1:0] line_bytes_t[$];

  typedef enum {ROW_TICKS, ROW_LINE} row_kind_e;

  // One directed row: a burst of ticks or one text line
  typedef struct {
    row_kind_e         kind;
    int                count;
    string             text;
    bit                has_term;
    logic [BYTE_W-1:0] term;
    string             tail;
    bit                has_golden;
    result_t           golden;
  } stim_row_t;

  localparam result_t NO_GOLDEN = '0;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   push       = 1'b0;
  logic                   command_i  = 1'b0;
  logic [BYTE_W-1:0]      rx_byte_i  = '0;
  logic                   line_end_i = 1'b0;
  logic                   pop        = 1'b0;
  logic                   full;
  logic                   empty;
  logic [LED_DRIVE_W-1:0] led_drive_o;
  logic [PERIOD_W-1:0]    period_ms_o;
  logic [LED_POS_W-1:0]   led_position_o;
  logic [2:0]             command_result_o;

  // Chaser state as the predictor sees it
  logic [10:0] chaser_period;
  count_t      chaser_count;
  logic        chaser_enabled;
  led_pos_t    chaser_index;
  pins_t       chaser_pins;
  match_pos_t  chaser_match_pos;
  cand_t       chaser_alive;
  logic        chaser_terminated;

  result_t   pending_status_q[$];
  result_t   oldest;
  stim_row_t directed_rows[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        error_count = 0;
  int        result_tally[7];

  uart_command_led_chaser u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .rx_byte_i        (rx_byte_i),
    .line_end_i       (line_end_i),
    .empty            (empty),
    .pop              (pop),
    .led_drive_o      (led_drive_o),
    .period_ms_o      (period_ms_o),
    .led_position_o   (led_position_o),
    .command_result_o (command_result_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic string command_text(hit_e c);
    case (c)
      HIT_START:   return "start";
      HIT_STOP:    return "stop";
      HIT_SPD100:  return "speed:100";
      HIT_SPD500:  return "speed:500";
      HIT_SPD1000: return "speed:1000";
      default:     return "";
    endcase
  endfunction

  // Advance the matcher by one line byte
  function automatic void scan_byte(logic [BYTE_W-1:0] b);
    string             txt;
    logic [BYTE_W-1:0] ch;
    if (chaser_terminated) return;
    if (b == CHAR_CR || b == CHAR_LF || b == CHAR_NUL) begin
      chaser_terminated = 1'b1;
      return;
    end
    for (int c = 0; c < CMD_COUNT; c++) begin
      txt = command_text(hit_e'(c));
      if (int'(chaser_match_pos) < txt.len()) begin
        ch = txt[chaser_match_pos];
        if (ch != b) chaser_alive[c] = 1'b0;
      end else begin
        chaser_alive[c] = 1'b0;
      end
    end
    if (chaser_match_pos != POS_MAX) chaser_match_pos++;
  endfunction

  // Act on the matched command at the end of a line
  function automatic res_e close_line();
    hit_e  hit = HIT_NONE;
    res_e  res = RES_IGNORED;
    string txt;
    for (int c = 0; c < CMD_COUNT; c++) begin
      txt = command_text(hit_e'(c));
      if (chaser_alive[c] && txt.len() == int'(chaser_match_pos)) hit = hit_e'(c);
    end
    case (hit)
      HIT_START: begin
        chaser_period  = 11'(PERIOD_START);
        chaser_enabled = 1'b1;
        res            = RES_START;
      end
      HIT_STOP: begin
        chaser_period  = '0;
        chaser_enabled = 1'b0;
        chaser_pins    = LEDS_OFF;
        res            = RES_STOP;
      end
      HIT_SPD100: if (chaser_period != 0) begin
        chaser_period = 11'(PERIOD_SPD100);
        res           = RES_SPD100;
      end
      HIT_SPD500: if (chaser_period != 0) begin
        chaser_period = 11'(PERIOD_SPD500);
        res           = RES_SPD500;
      end
      HIT_SPD1000: if (chaser_period != 0) begin
        chaser_period = 11'(PERIOD_SPD1000);
        res           = RES_SPD1000;
      end
      default: ;
    endcase
    chaser_match_pos  = '0;
    chaser_alive      = '1;
    chaser_terminated = 1'b0;
    return res;
  endfunction

  // Predict the status that one item leaves behind
  function automatic result_t step_chaser(logic cmd, logic [BYTE_W-1:0] b, logic le);
    result_t r;
    res_e    res = RES_NONE;
    if (cmd) begin
      if (chaser_enabled) chaser_count = chaser_count + 1'b1;
    end else begin
      scan_byte(b);
      if (le) res = close_line();
    end
    if (chaser_period != 0 && chaser_count >= chaser_period) begin
      chaser_count = '0;
      chaser_pins  = LEDS_OFF & ~(pins_t'(1) << chaser_index);
      chaser_index = (chaser_index == led_pos_t'(LED_NUMBER - 1)) ? '0 : chaser_index + 1'b1;
    end
    r.led_drive      = drive_t'(chaser_pins);
    r.period_ms      = period_t'(chaser_period);
    r.led_position   = chaser_index;
    r.command_result = res;
    return r;
  endfunction

  function automatic line_bytes_t text_bytes(string s);
    line_bytes_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [BYTE_W-1:0] random_terminator();
    case ($urandom_range(2))
      0:       return CHAR_CR;
      1:       return CHAR_LF;
      default: return CHAR_NUL;
    endcase
  endfunction

  function automatic stim_row_t line_row(string text, bit has_term, logic [BYTE_W-1:0] term,
                                         string tail, bit has_golden, result_t golden);
    stim_row_t r;
    r.kind       = ROW_LINE;
    r.count      = 0;
    r.text       = text;
    r.has_term   = has_term;
    r.term       = term;
    r.tail       = tail;
    r.has_golden = has_golden;
    r.golden     = golden;
    return r;
  endfunction

  function automatic stim_row_t tick_row(int count, bit has_golden, result_t golden);
    stim_row_t r;
    r.kind       = ROW_TICKS;
    r.count      = count;
    r.text       = "";
    r.has_term   = 1'b0;
    r.term       = '0;
    r.tail       = "";
    r.has_golden = has_golden;
    r.golden     = golden;
    return r;
  endfunction

  // Transfer one item and queue its expected status
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b, input logic le,
                           input bit has_golden, input result_t golden);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push       <= 1'b1;
    command_i  <= cmd;
    rx_byte_i  <= b;
    line_end_i <= le;
    do @(posedge clk_i); while (full);
    predicted = step_chaser(cmd, b, le);
    pending_status_q.push_back(has_golden ? golden : predicted);
    items_sent++;
  endtask

  task automatic send_line(input line_bytes_t line, input bit has_golden, input result_t golden);
    for (int i = 0; i < line.size(); i++) begin
      send_item(1'b0, line[i], i == line.size() - 1, has_golden && i == line.size() - 1,
                golden);
    end
  endtask

  // Tick fields carry random bytes and line ends, which must be ignored
  task automatic send_ticks(input int n, input bit has_golden, input result_t golden);
    for (int i = 0; i < n; i++) begin
      send_item(1'b1, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                has_golden && i == n - 1, golden);
    end
  endtask

  // Mostly valid commands, some corrupted, truncated or garbage lines
  task automatic send_random_line();
    line_bytes_t line;
    int          pick;
    int          weight;
    hit_e        c;
    pick   = $urandom_range(99);
    weight = $urandom_range(99);
    c = (weight < 25) ? HIT_START : (weight < 35) ? HIT_STOP : hit_e'($urandom_range(4, 2));
    line = text_bytes(command_text(c));
    if (pick < 70) begin
      if ($urandom_range(4) == 0) begin
        line.push_back(random_terminator());
        repeat ($urandom_range(3)) line.push_back(BYTE_W'($urandom_range(255)));
      end
    end else if (pick < 82) begin
      line[$urandom_range(line.size() - 1)] = BYTE_W'($urandom_range(255));
    end else if (pick < 90) begin
      if ($urandom_range(1)) void'(line.pop_back());
      else line.push_back(BYTE_W'($urandom_range(255)));
    end else begin
      line.delete();
      repeat ($urandom_range(16)) line.push_back(BYTE_W'($urandom_range(255)));
      if (line.size() == 0) line.push_back(random_terminator());
    end
    send_line(line, 1'b0, NO_GOLDEN);
  endtask

  task automatic run_random(input int target);
    int stop_at;
    int pick;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_random_line();
      end else if (pick < 52) begin
        repeat ($urandom_range(3, 1))
          send_item(1'b0, BYTE_W'($urandom_range(255)), 1'b0, 1'b0, NO_GOLDEN);
      end else begin
        send_ticks(($urandom_range(4) == 0) ? $urandom_range(260, 100) : $urandom_range(40, 1),
                   1'b0, NO_GOLDEN);
      end
    end
  endtask

  // Check each result transfer and decide the next pop
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_status_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual drive=%0d period=%0d pos=%0d res=%0d",
                 $time, led_drive_o, period_ms_o, led_position_o, command_result_o);
        error_count++;
      end else begin
        oldest = pending_status_q.pop_front();
        results_checked++;
        if (command_result_o < 7) result_tally[command_result_o]++;
        if (led_drive_o !== oldest.led_drive) begin
          $display("%0t: led_drive expected %0d actual %0d", $time, oldest.led_drive,
                   led_drive_o);
          error_count++;
        end
        if (period_ms_o !== oldest.period_ms) begin
          $display("%0t: period_ms expected %0d actual %0d", $time, oldest.period_ms,
                   period_ms_o);
          error_count++;
        end
        if (led_position_o !== oldest.led_position) begin
          $display("%0t: led_position expected %0d actual %0d", $time, oldest.led_position,
                   led_position_o);
          error_count++;
        end
        if (command_result_o !== oldest.command_result) begin
          $display("%0t: command_result expected %0d actual %0d", $time,
                   oldest.command_result, command_result_o);
          error_count++;
        end
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    line_bytes_t line;

    // Hold reset, then start from the reset state
    send_idle_pct = 7;
    recv_idle_pct = 59;
    chaser_period     = '0;
    chaser_count      = '0;
    chaser_enabled    = 1'b1;
    chaser_index      = '0;
    chaser_pins       = LEDS_OFF;
    chaser_match_pos  = '0;
    chaser_alive      = '1;
    chaser_terminated = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; golden status only where it is plain to read
    directed_rows.push_back(tick_row(1, 1'b1,
      '{drive_t'(LEDS_OFF), period_t'(0), led_pos_t'(0), RES_NONE}));
    directed_rows.push_back(line_row("speed:100", 1'b0, CHAR_CR, "", 1'b1,
      '{drive_t'(LEDS_OFF), period_t'(0), led_pos_t'(0), RES_IGNORED}));
    directed_rows.push_back(line_row("", 1'b1, CHAR_CR, "", 1'b1,
      '{drive_t'(LEDS_OFF), period_t'(0), led_pos_t'(0), RES_IGNORED}));
    // Count past the start period while the period is 0, then start steps at once
    directed_rows.push_back(tick_row(IDLE_TICKS, 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("start", 1'b0, CHAR_CR, "", 1'b1,
      '{drive_t'(5'b11110), PERIOD_START, led_pos_t'(1), RES_START}));
    directed_rows.push_back(line_row("stop", 1'b1, CHAR_NUL, "start", 1'b1,
      '{drive_t'(LEDS_OFF), period_t'(0), led_pos_t'(1), RES_STOP}));
    directed_rows.push_back(tick_row(20, 1'b1,
      '{drive_t'(LEDS_OFF), period_t'(0), led_pos_t'(1), RES_NONE}));
    directed_rows.push_back(line_row("speed:500", 1'b0, CHAR_CR, "", 1'b1,
      '{drive_t'(LEDS_OFF), period_t'(0), led_pos_t'(1), RES_IGNORED}));
    directed_rows.push_back(line_row("start", 1'b0, CHAR_CR, "", 1'b1,
      '{drive_t'(LEDS_OFF), PERIOD_START, led_pos_t'(1), RES_START}));
    directed_rows.push_back(tick_row(110, 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("speed:1000", 1'b0, CHAR_CR, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("speed:500", 1'b1, CHAR_CR, "xyz", 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("speed:100", 1'b1, CHAR_LF, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("starts", 1'b0, CHAR_CR, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("sta", 1'b0, CHAR_CR, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("speed:1000speed:1000xx", 1'b0, CHAR_CR, "", 1'b0,
                                     NO_GOLDEN));
    directed_rows.push_back(line_row("STOP", 1'b0, CHAR_CR, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("\377\200\001", 1'b0, CHAR_CR, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(tick_row(100, 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("stop", 1'b0, CHAR_CR, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(line_row("start", 1'b0, CHAR_CR, "", 1'b0, NO_GOLDEN));
    directed_rows.push_back(tick_row(30, 1'b0, NO_GOLDEN));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_TICKS) begin
        send_ticks(directed_rows[i].count, directed_rows[i].has_golden,
                   directed_rows[i].golden);
      end else begin
        line = text_bytes(directed_rows[i].text);
        if (directed_rows[i].has_term) line.push_back(directed_rows[i].term);
        line = {line, text_bytes(directed_rows[i].tail)};
        send_line(line, directed_rows[i].has_golden, directed_rows[i].golden);
      end
    end

    // Random traffic under three idling patterns
    run_random(PHASE_ITEMS);
    send_idle_pct = 59;
    recv_idle_pct = 7;
    run_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);
    push <= 1'b0;

    // Drain, then allow for any stray result
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d item transfers and %0d checked results, idle start included.",
             items_sent, results_checked);
    $display("Results seen: start %0d, stop %0d, speed %0d/%0d/%0d, ignored %0d, none %0d",
             result_tally[RES_START], result_tally[RES_STOP], result_tally[RES_SPD100],
             result_tally[RES_SPD500], result_tally[RES_SPD1000], result_tally[RES_IGNORED],
             result_tally[RES_NONE]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
